@@ rtl/stwa_pkg.sv @@
// ----------------------------------------------------------------------------
// stwa_pkg
// Types, constants and state codes shared by the spanning tree weight
// average block.
// ----------------------------------------------------------------------------
package stwa_pkg;

	localparam int NODE_W     = 7;
	localparam int WEIGHT_W   = 16;
	localparam int NUM_W      = 24;
	localparam int DEN_W      = 2;

	localparam int DEF_MAX_NODES   = 128;
	localparam int DEF_MAX_EDGES   = 16384;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [NUM_W-1:0]  NUM_MAX = 24'hFF_FFFF;
	localparam logic [DEN_W-1:0]  DEN_ONE = 2'd1;
	localparam logic [DEN_W-1:0]  DEN_TWO = 2'd2;
	localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd127;

	typedef struct packed {
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
		logic                is_end;
	} in_t;

	typedef struct packed {
		logic [NUM_W-1:0] numerator;
		logic [DEN_W-1:0] denominator;
	} out_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_CLR,
		ST_E_RD,
		ST_E_WAIT,
		ST_FA_RD,
		ST_FA_CHK,
		ST_FB_RD,
		ST_FB_CHK,
		ST_FINISH
	} state_t;

endpackage

@@ rtl/stwa_front.sv @@
// ----------------------------------------------------------------------------
// stwa_front
// Accepts input items, drops edges whose endpoints lie outside the node
// table and passes the rest to the queue.
// ----------------------------------------------------------------------------
module stwa_front #(
	parameter int MAX_NODES = stwa_pkg::DEF_MAX_NODES
) (
	input  logic                edge_valid,
	output logic                edge_stall,
	input  stwa_pkg::in_t       edge_data,
	input  stwa_pkg::q_status_t q_status,
	output logic                push,
	output stwa_pkg::in_t       push_data
);

	logic in_range;

	assign in_range   = (32'(edge_data.node_a) < 32'(MAX_NODES))
	                 && (32'(edge_data.node_b) < 32'(MAX_NODES));
	assign edge_stall = q_status.full;
	// When the queue has room, an end item always goes through; an edge only when both endpoints exist.
	assign push       = edge_valid && !q_status.full && (edge_data.is_end || in_range);
	assign push_data  = edge_data;

endmodule

@@ rtl/stwa_queue.sv @@
// ----------------------------------------------------------------------------
// stwa_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module stwa_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  stwa_pkg::in_t       push_data,
	input  logic                pop,
	output stwa_pkg::in_t       pop_data,
	output stwa_pkg::q_status_t status
);

	stwa_pkg::in_t                   entry_q [stwa_pkg::QUEUE_DEPTH];
	logic [stwa_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [stwa_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [stwa_pkg::QUEUE_AW:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_ptr_q];
	assign status.full  = (count_q == (stwa_pkg::QUEUE_AW+1)'(stwa_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

@@ rtl/stwa_back.sv @@
// ----------------------------------------------------------------------------
// stwa_back
// Stores edges, sorts them by weight with a bitwise radix sort between two
// memories, runs both spanning forest passes with a union-find table and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module stwa_back #(
	parameter int MAX_NODES   = stwa_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES   = stwa_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = stwa_pkg::DEF_WEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stwa_pkg::q_status_t q_status,
	input  stwa_pkg::in_t       q_data,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output stwa_pkg::out_t      result_data
);

	localparam int NB   = $clog2(MAX_NODES);
	localparam int IW   = $clog2(MAX_EDGES);
	localparam int CW   = $clog2(MAX_EDGES + 1);
	localparam int WB   = WEIGHT_BITS;
	localparam int EW   = 2 * NB + WB;
	localparam int PW   = (WB > 1) ? $clog2(WB) : 1;
	localparam int SUMW = ((WB > stwa_pkg::NUM_W) ? WB : stwa_pkg::NUM_W) + 1;

	stwa_pkg::state_t state_q, state_d;

	logic [EW-1:0] mem0 [MAX_EDGES];
	logic [EW-1:0] mem1 [MAX_EDGES];
	logic [EW-1:0] rdata0_q, rdata1_q;
	logic [NB-1:0] parent [MAX_NODES];
	logic [NB-1:0] prdata_q;

	logic [CW-1:0] total_q;
	logic [CW-1:0] rd_i_q;
	logic [CW-1:0] wr_p_q;
	logic [CW-1:0] k_i_q;
	logic [CW-1:0] edge_idx;
	logic [PW-1:0] pass_q;
	logic          phase_q;
	logic          src_q;
	logic          kdir_q;
	logic          rd_v_s1;
	logic [NB-1:0] clr_q;
	logic          out_valid_q;

	logic [EW-1:0] edge_q;
	logic [NB-1:0] x_q;
	logic [NB-1:0] ra_q;
	logic [stwa_pkg::NUM_W-1:0] sum_q;
	stwa_pkg::out_t out_q;

	logic          we0, we1, pwe;
	logic [IW-1:0] ra, wa;
	logic [EW-1:0] wd;
	logic [NB-1:0] pwa, pwd;

	logic [EW-1:0] sort_rd;
	logic [WB-1:0] sort_w;
	logic          sort_match;
	logic          sort_done;
	logic          out_free;
	logic          is_edge, is_end_item;
	logic [EW-1:0] load_edge;
	logic [SUMW-1:0] sum_ext;
	logic [stwa_pkg::NUM_W-1:0] sum_sat;
	stwa_pkg::out_t result;

	assign sort_rd     = src_q ? rdata1_q : rdata0_q;
	assign sort_w      = sort_rd[EW-1 -: WB];
	assign sort_match  = rd_v_s1 && (sort_w[pass_q] == phase_q);
	assign sort_done   = (rd_i_q == total_q) && !rd_v_s1;
	assign out_free    = !out_valid_q || !result_stall;
	assign pop         = (state_q == stwa_pkg::ST_IDLE) && !q_status.empty;
	assign is_edge     = pop && !q_data.is_end;
	assign is_end_item = pop && q_data.is_end;
	assign load_edge   = {WB'(q_data.weight), NB'(q_data.node_a), NB'(q_data.node_b)};
	assign edge_idx    = kdir_q ? (total_q - CW'(1) - k_i_q) : k_i_q;
	assign sum_ext     = SUMW'(sum_q) + SUMW'(edge_q[EW-1 -: WB]);
	assign sum_sat     = (sum_ext > SUMW'(stwa_pkg::NUM_MAX)) ? stwa_pkg::NUM_MAX
	                                                         : sum_ext[stwa_pkg::NUM_W-1:0];

	always_comb begin
		if (sum_q == '0) begin
			result.numerator   = '0;
			result.denominator = stwa_pkg::DEN_ONE;
		end else if (!sum_q[0]) begin
			result.numerator   = sum_q >> 1;
			result.denominator = stwa_pkg::DEN_ONE;
		end else begin
			result.numerator   = sum_q;
			result.denominator = stwa_pkg::DEN_TWO;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			stwa_pkg::ST_IDLE: begin
				if (is_end_item) begin
					state_d = (total_q == '0) ? stwa_pkg::ST_FINISH : stwa_pkg::ST_SORT;
				end
			end
			stwa_pkg::ST_SORT: begin
				if (sort_done && phase_q && (pass_q == PW'(WB - 1))) begin
					state_d = stwa_pkg::ST_CLR;
				end
			end
			stwa_pkg::ST_CLR: begin
				if (clr_q == NB'(MAX_NODES - 1)) begin
					state_d = stwa_pkg::ST_E_RD;
				end
			end
			stwa_pkg::ST_E_RD: begin
				if (k_i_q == total_q) begin
					state_d = kdir_q ? stwa_pkg::ST_FINISH : stwa_pkg::ST_CLR;
				end else begin
					state_d = stwa_pkg::ST_E_WAIT;
				end
			end
			stwa_pkg::ST_E_WAIT:  state_d = stwa_pkg::ST_FA_RD;
			stwa_pkg::ST_FA_RD:   state_d = stwa_pkg::ST_FA_CHK;
			stwa_pkg::ST_FA_CHK: begin
				state_d = (prdata_q == x_q) ? stwa_pkg::ST_FB_RD : stwa_pkg::ST_FA_RD;
			end
			stwa_pkg::ST_FB_RD:   state_d = stwa_pkg::ST_FB_CHK;
			stwa_pkg::ST_FB_CHK: begin
				state_d = (prdata_q == x_q) ? stwa_pkg::ST_E_RD : stwa_pkg::ST_FB_RD;
			end
			stwa_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = stwa_pkg::ST_IDLE;
				end
			end
			default: state_d = stwa_pkg::ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		we0 = 1'b0;
		we1 = 1'b0;
		pwe = 1'b0;
		ra  = '0;
		wa  = '0;
		wd  = load_edge;
		pwa = clr_q;
		pwd = clr_q;
		case (state_q)
			stwa_pkg::ST_IDLE: begin
				we0 = is_edge && (total_q != CW'(MAX_EDGES));
				wa  = total_q[IW-1:0];
			end
			stwa_pkg::ST_SORT: begin
				ra  = rd_i_q[IW-1:0];
				wa  = wr_p_q[IW-1:0];
				wd  = sort_rd;
				we0 = sort_match && src_q;
				we1 = sort_match && !src_q;
			end
			stwa_pkg::ST_CLR: begin
				pwe = 1'b1;
			end
			stwa_pkg::ST_E_RD: begin
				ra = edge_idx[IW-1:0];
			end
			stwa_pkg::ST_FB_CHK: begin
				// Both roots known: join the two trees when they differ.
				pwe = (prdata_q == x_q) && (ra_q != x_q);
				pwa = ra_q;
				pwd = x_q;
			end
			default: begin
				we0 = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[wa] <= wd;
		end
		rdata0_q <= mem0[ra];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[wa] <= wd;
		end
		rdata1_q <= mem1[ra];
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			parent[pwa] <= pwd;
		end
		prdata_q <= parent[x_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stwa_pkg::ST_IDLE;
			total_q     <= '0;
			rd_i_q      <= '0;
			wr_p_q      <= '0;
			k_i_q       <= '0;
			pass_q      <= '0;
			phase_q     <= 1'b0;
			src_q       <= 1'b0;
			kdir_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == stwa_pkg::ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				stwa_pkg::ST_IDLE: begin
					if (is_edge && (total_q != CW'(MAX_EDGES))) begin
						total_q <= total_q + CW'(1);
					end
					if (is_end_item) begin
						rd_i_q  <= '0;
						wr_p_q  <= '0;
						k_i_q   <= '0;
						pass_q  <= '0;
						phase_q <= 1'b0;
						src_q   <= 1'b0;
						kdir_q  <= 1'b0;
						rd_v_s1 <= 1'b0;
						clr_q   <= '0;
					end
				end
				stwa_pkg::ST_SORT: begin
					if (rd_i_q != total_q) begin
						rd_i_q  <= rd_i_q + CW'(1);
						rd_v_s1 <= 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (sort_match) begin
						wr_p_q <= wr_p_q + CW'(1);
					end
					// Zeros of this bit first, then ones, keeping order within each.
					if (sort_done) begin
						rd_i_q <= '0;
						if (!phase_q) begin
							phase_q <= 1'b1;
						end else begin
							phase_q <= 1'b0;
							wr_p_q  <= '0;
							pass_q  <= pass_q + PW'(1);
							src_q   <= !src_q;
						end
					end
				end
				stwa_pkg::ST_CLR: begin
					clr_q <= (clr_q == NB'(MAX_NODES - 1)) ? '0 : clr_q + NB'(1);
				end
				stwa_pkg::ST_E_RD: begin
					if ((k_i_q == total_q) && !kdir_q) begin
						kdir_q <= 1'b1;
						k_i_q  <= '0;
					end
				end
				stwa_pkg::ST_FB_CHK: begin
					if (prdata_q == x_q) begin
						k_i_q <= k_i_q + CW'(1);
					end
				end
				stwa_pkg::ST_FINISH: begin
					if (out_free) begin
						total_q <= '0;
					end
				end
				default: begin
					rd_v_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			stwa_pkg::ST_IDLE: begin
				if (is_end_item) begin
					sum_q <= '0;
				end
			end
			stwa_pkg::ST_E_WAIT: begin
				edge_q <= sort_rd;
				x_q    <= sort_rd[2*NB-1:NB];
			end
			stwa_pkg::ST_FA_CHK: begin
				if (prdata_q == x_q) begin
					ra_q <= x_q;
					x_q  <= edge_q[NB-1:0];
				end else begin
					x_q <= prdata_q;
				end
			end
			stwa_pkg::ST_FB_CHK: begin
				if (prdata_q == x_q) begin
					if (ra_q != x_q) begin
						sum_q <= sum_sat;
					end
				end else begin
					x_q <= prdata_q;
				end
			end
			stwa_pkg::ST_FINISH: begin
				if (out_free) begin
					out_q <= result;
				end
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_EDGES))
		else $error("edge count beyond store depth");

	a_sort_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stwa_pkg::ST_SORT) |-> (wr_p_q <= total_q))
		else $error("sort write pointer beyond edge count");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stwa_pkg::ST_FINISH && out_free) |=> (out_valid_q && total_q == '0))
		else $error("result not registered at end of set");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.denominator == stwa_pkg::DEN_ONE
		             || out_q.denominator == stwa_pkg::DEN_TWO))
		else $error("denominator out of range");
`endif

endmodule

@@ rtl/spanning_tree_weight_average.sv @@
// ----------------------------------------------------------------------------
// spanning_tree_weight_average
// Half the sum of the minimum and maximum spanning forest weights of a set
// of edges, as a reduced fraction.
// ----------------------------------------------------------------------------
// Edges arrive on the edge channel (edge_valid, edge_stall, edge_data), one
// transfer per cycle while the four-entry queue has room. An item with
// is_end set closes the set; it causes one transfer on the result channel.
// Edges with an endpoint outside the node table, and edges beyond the store
// depth, are dropped.
// On the end item the back end sorts the stored edges by weight, one bit of
// weight per pass; a pass moves zeros, then ones, to the other memory. Each
// forest pass then clears the parent table and, for each edge, follows the
// parent table to the roots of both endpoints and joins the two trees when
// they differ. The result register then holds the answer until the receiver
// takes it; a stalled result holds the back end, and the queue then fills
// and stalls the input.
// cfg_data writes node_count whenever cfg_valid is high; it is held only.
// Reset clears the edge count and all control state; no memory is cleared.
// ----------------------------------------------------------------------------
module spanning_tree_weight_average #(
	parameter int MAX_NODES   = stwa_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES   = stwa_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = stwa_pkg::DEF_WEIGHT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          edge_valid,
	output logic                          edge_stall,
	input  stwa_pkg::in_t                 edge_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output stwa_pkg::out_t                result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stwa_pkg::NODE_W-1:0]   cfg_data
);

	logic [stwa_pkg::NODE_W-1:0] node_count_q;
	stwa_pkg::q_status_t         q_status;
	stwa_pkg::in_t               push_data, pop_data;
	logic                        push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= stwa_pkg::NODE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	stwa_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.edge_valid (edge_valid),
		.edge_stall (edge_stall),
		.edge_data  (edge_data),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	stwa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	stwa_back #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.q_data       (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
